[hdl/cia_pkg.sv]
// ----------------------------------------------------------------------------
// cia_pkg: shared types and constants for the checked integer ALU
// Operation codes, status codes and the record carried between pipeline cells.
// ----------------------------------------------------------------------------
package cia_pkg;

    localparam int unsigned ActionWidth = 3;
    localparam int unsigned StatusWidth = 2;
    localparam int unsigned OutWidth    = 64;

    typedef enum logic [ActionWidth-1:0] {
        ACT_ADD = 3'd0,
        ACT_SUB = 3'd1,
        ACT_MUL = 3'd2,
        ACT_DIV = 3'd3,
        ACT_REM = 3'd4,
        ACT_NEG = 3'd5,
        ACT_NOP6 = 3'd6,
        ACT_NOP7 = 3'd7
    } action_t;

    typedef enum logic [StatusWidth-1:0] {
        ST_OK   = 2'd0,
        ST_OVF  = 2'd1,
        ST_DIV0 = 2'd2,
        ST_RSVD = 2'd3
    } status_t;

    // Control record that travels with each beat through the cell chain
    typedef struct packed {
        logic    valid;
        action_t action;
        status_t status;
        logic    q_neg;     // negate quotient at the end, product in the front
        logic    r_neg;     // negate remainder at the end
    } cell_ctl_t;

endpackage

[hdl/checked_integer_alu_unit.sv]
// ----------------------------------------------------------------------------
// checked_integer_alu_unit: overflow-checked signed integer ALU
// Add, subtract, multiply, divide, remainder and negate with status.
//
//  channel | ports                                     | dir
//  input   | s_valid s_ready s_action s_operand_a/b    | in
//  result  | m_valid m_ready m_value_out m_status      | out
//
// One beat enters per cycle while the chain advances. Every operation passes
// the front stages, DATA_WIDTH division cells (one quotient bit each) and the
// output register. The chain advances as one when the output register is
// free or being drained. Reset clears all valid bits; no clearing pass.
// ----------------------------------------------------------------------------
module checked_integer_alu_unit #(
    parameter int unsigned DATA_WIDTH = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [cia_pkg::ActionWidth-1:0] s_action,
    input  logic signed [63:0]            s_operand_a,
    input  logic signed [63:0]            s_operand_b,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [63:0]            m_value_out,
    output logic [cia_pkg::StatusWidth-1:0] m_status
);
    import cia_pkg::*;

    localparam int unsigned W = DATA_WIDTH;

    logic      advance;
    cell_ctl_t ctl   [0:W];
    logic [W-1:0] rem [0:W];
    logic [W-1:0] quo [0:W];
    logic [W-1:0] dv  [0:W];
    logic [W-1:0] res [0:W];

    logic         out_valid_reg;
    logic [63:0]  out_value_reg;
    status_t      out_status_reg;
    logic [W-1:0] fin;
    logic [W-1:0] qv, rv;
    cell_ctl_t    last;

    // Stall the whole chain only when the output register is full and held
    assign advance = !out_valid_reg || m_ready;
    assign s_ready = advance;

    cia_front #(.W(W)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .in_valid (s_valid),
        .action   (action_t'(s_action)),
        .a        (s_operand_a[W-1:0]),
        .b        (s_operand_b[W-1:0]),
        .ctl_out  (ctl[0]),
        .quo_out  (quo[0]),
        .div_out  (dv[0]),
        .res_out  (res[0])
    );
    assign rem[0] = '0;

    // Division cells, most significant quotient bit first
    for (genvar i = 0; i < W; i++) begin : g_cell
        cia_cell #(.W(W), .BIT(W-1-i)) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .advance (advance),
            .ctl_in  (ctl[i]),
            .rem_in  (rem[i]),
            .quo_in  (quo[i]),
            .div_in  (dv[i]),
            .res_in  (res[i]),
            .ctl_out (ctl[i+1]),
            .rem_out (rem[i+1]),
            .quo_out (quo[i+1]),
            .div_out (dv[i+1]),
            .res_out (res[i+1])
        );
    end

    // Pick the final value and apply signs
    always_comb begin
        last = ctl[W];
        qv   = last.q_neg ? (~quo[W] + 1'b1) : quo[W];
        rv   = last.r_neg ? (~rem[W] + 1'b1) : rem[W];
        case (last.action)
            ACT_DIV: fin = qv;
            ACT_REM: fin = rv;
            default: fin = res[W];
        endcase
        if (last.status != ST_OK) fin = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= last.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_value_reg  <= 64'(signed'(fin));
            out_status_reg <= last.status;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_value_out = out_value_reg;
    assign m_status    = out_status_reg;

`ifndef NO_ASSERTIONS
    // A held result must not change while the consumer stalls
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_value_out) && $stable(m_status))
        else $error("result changed under stall");
    // Non-ok status always carries a zero value
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_value_out == '0)
        else $error("flagged result not zero");
    // Status never takes the reserved code
    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status != ST_RSVD)
        else $error("reserved status");
    // Input is refused only while a result stalls
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("ready dropped without stall");
`endif

endmodule

[hdl/cia_cell.sv]
// ----------------------------------------------------------------------------
// cia_cell: one restoring-division step cell
// Resolves one quotient bit per cycle while advance is high and passes the partial remainder on.
// ----------------------------------------------------------------------------
module cia_cell #(
    parameter int unsigned W   = 64,
    parameter int unsigned BIT = 0
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  cia_pkg::cell_ctl_t  ctl_in,
    input  logic [W-1:0]        rem_in,
    input  logic [W-1:0]        quo_in,
    input  logic [W-1:0]        div_in,
    input  logic [W-1:0]        res_in,
    output cia_pkg::cell_ctl_t  ctl_out,
    output logic [W-1:0]        rem_out,
    output logic [W-1:0]        quo_out,
    output logic [W-1:0]        div_out,
    output logic [W-1:0]        res_out
);
    import cia_pkg::*;

    cell_ctl_t    ctl_reg;
    logic [W-1:0] rem_reg, quo_reg, div_reg, res_reg;
    logic [W:0]   trial;
    logic [W:0]   diff;
    logic [W-1:0] rem_next, quo_next;

    // Shift in the next dividend bit and try to subtract the divisor
    always_comb begin
        trial    = {rem_in, quo_in[BIT]};
        diff     = trial - {1'b0, div_in};
        rem_next = diff[W] ? trial[W-1:0] : diff[W-1:0];
        quo_next = quo_in;
        quo_next[BIT] = ~diff[W];
    end

    // Hold the control word; only valid needs reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (advance) begin
            ctl_reg <= ctl_in;
        end
    end

    // Advance the datapath
    always_ff @(posedge aclk) begin
        if (advance) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            div_reg <= div_in;
            res_reg <= res_in;
        end
    end

    assign ctl_out = ctl_reg;
    assign rem_out = rem_reg;
    assign quo_out = quo_reg;
    assign div_out = div_reg;
    assign res_out = res_reg;

endmodule

[hdl/cia_front.sv]
// ----------------------------------------------------------------------------
// cia_front: operand decode and the non-division operations
// Computes add, sub, negate and the checked multiply, flags divide errors; prepares magnitudes.
// ----------------------------------------------------------------------------
module cia_front #(
    parameter int unsigned W = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  logic                in_valid,
    input  cia_pkg::action_t    action,
    input  logic [W-1:0]        a,
    input  logic [W-1:0]        b,
    output cia_pkg::cell_ctl_t  ctl_out,
    output logic [W-1:0]        quo_out,
    output logic [W-1:0]        div_out,
    output logic [W-1:0]        res_out
);
    import cia_pkg::*;

    localparam int unsigned HW = (W + 1) / 2;
    localparam int unsigned LW = W - HW;

    logic         sa, sb, neg;
    logic [W-1:0] ma, mb;
    logic [W-1:0] sum, dif, nega;
    logic [W-1:0] smin, sall;

    // Stage one registers: control, early result, magnitudes and partial products for the multiply
    cell_ctl_t        c1_reg;
    logic [W-1:0]     r1_reg, q1_reg, d1_reg;
    logic [2*LW-1:0]  pll_reg;
    logic [LW+HW-1:0] plh_reg, phl_reg;
    logic [2*HW-1:0]  phh_reg;

    cell_ctl_t        c1_next;
    logic [W-1:0]     r1_next;

    logic [2*W-1:0]   prod;
    logic [W-1:0]     limit;
    cell_ctl_t        c2_next;
    logic [W-1:0]     r2_next;

    assign sa   = a[W-1];
    assign sb   = b[W-1];
    assign neg  = sa ^ sb;
    assign ma   = sa ? (~a + 1'b1) : a;
    assign mb   = sb ? (~b + 1'b1) : b;
    assign sum  = a + b;
    assign dif  = a - b;
    assign nega = ~a + 1'b1;
    assign smin = {1'b1, {(W-1){1'b0}}};
    assign sall = '1;

    // Decode the operation and compute the add, sub and negate results
    always_comb begin
        c1_next        = '0;
        c1_next.valid  = in_valid;
        c1_next.action = action;
        c1_next.status = ST_OK;
        c1_next.q_neg  = neg;
        c1_next.r_neg  = sa;
        r1_next        = '0;
        unique case (action)
            ACT_ADD: begin
                r1_next = sum;
                if ((a[W-1] ^ sum[W-1]) & (b[W-1] ^ sum[W-1])) c1_next.status = ST_OVF;
            end
            ACT_SUB: begin
                r1_next = dif;
                if ((a[W-1] ^ b[W-1]) & (a[W-1] ^ dif[W-1])) c1_next.status = ST_OVF;
            end
            ACT_DIV, ACT_REM: begin
                if (b == '0) c1_next.status = ST_DIV0;
                else if (a == smin && b == sall) c1_next.status = ST_OVF;
            end
            ACT_NEG: begin
                if (a == smin) c1_next.status = ST_OVF;
                else r1_next = nega;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c1_reg <= '0;
        end else if (advance) begin
            c1_reg <= c1_next;
        end
    end

    // Capture the four half-width partial products and the magnitudes
    always_ff @(posedge aclk) begin
        if (advance) begin
            r1_reg  <= r1_next;
            q1_reg  <= ma;
            d1_reg  <= mb;
            pll_reg <= ma[LW-1:0] * mb[LW-1:0];
            plh_reg <= ma[LW-1:0] * mb[W-1:LW];
            phl_reg <= ma[W-1:LW] * mb[LW-1:0];
            phh_reg <= ma[W-1:LW] * mb[W-1:LW];
        end
    end

    // Sum the partial products and check the multiply range
    always_comb begin
        prod = {{(2*W-2*LW){1'b0}}, pll_reg}
             + ({{HW{1'b0}}, plh_reg, {LW{1'b0}}})
             + ({{HW{1'b0}}, phl_reg, {LW{1'b0}}})
             + ({phh_reg, {(2*LW){1'b0}}});
        limit   = c1_reg.q_neg ? smin : {1'b0, {(W-1){1'b1}}};
        c2_next = c1_reg;
        r2_next = r1_reg;
        if (c1_reg.action == ACT_MUL) begin
            if (prod[2*W-1:W] != '0 || prod[W-1:0] > limit) begin
                c2_next.status = ST_OVF;
            end else begin
                r2_next = c1_reg.q_neg ? (~prod[W-1:0] + 1'b1) : prod[W-1:0];
            end
        end
    end

    logic [W-1:0] q2_reg, d2_reg, r2_reg;
    cell_ctl_t    c2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c2_reg <= '0;
        end else if (advance) begin
            c2_reg <= c2_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            r2_reg <= r2_next;
            q2_reg <= q1_reg;
            d2_reg <= (d1_reg == '0) ? {{(W-1){1'b0}}, 1'b1} : d1_reg;
        end
    end

    assign ctl_out = c2_reg;
    assign quo_out = q2_reg;
    assign div_out = d2_reg;
    assign res_out = r2_reg;

endmodule
